// ===== src/lnds_pkg.sv =====
// Shared constants and types for the longest non-decreasing subsequence block.
`default_nettype none
package lnds_pkg;

  localparam int MAX_LEN = 1024;
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int VAL_W   = 32;
  localparam int SLOT_W  = 10;
  localparam int RUN_W   = 11;

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic                    restart;
    logic                    placed;
    logic [SLOT_W-1:0]       slot;
    logic [RUN_W-1:0]        count;
  } item_t;

endpackage
`default_nettype wire

// ===== src/lnds_if.sv =====
// Request and result channel interfaces of the subsequence block.
`default_nettype none
interface lnds_req_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [lnds_pkg::VAL_W-1:0]      value;
  logic                                    restart;

  modport source (output valid, output value, output restart, input ready);
  modport sink   (input valid, input value, input restart, output ready);
endinterface

interface lnds_res_if;
  logic                          valid;
  logic                          ready;
  logic [lnds_pkg::SLOT_W-1:0]   slot;
  logic [lnds_pkg::RUN_W-1:0]    run_length;
  logic                          overflow;

  modport source (output valid, output slot, output run_length, output overflow, input ready);
  modport sink   (input valid, input slot, input run_length, input overflow, output ready);
endinterface
`default_nettype wire

// ===== src/lnds_cell.sv =====
// One tail cell: holds one tail of the store and passes the request to its neighbor.
`default_nettype none
module lnds_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      enable,
  input  wire logic [lnds_pkg::IDX_W-1:0] idx,
  input  wire lnds_pkg::item_t           up,
  output lnds_pkg::item_t                down
);

  logic                             live;
  logic signed [lnds_pkg::VAL_W-1:0] tail;
  logic                             live_eff;
  logic                             hit;
  logic                             live_next;
  logic [lnds_pkg::RUN_W-1:0]       here_count;

  assign live_eff   = live & ~(up.valid & up.restart);
  assign hit        = up.valid & ~up.placed & (~live_eff | (tail > up.value));
  assign live_next  = live_eff | hit;
  assign here_count = lnds_pkg::RUN_W'({1'b0, idx} + (lnds_pkg::IDX_W + 1)'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      live       <= 1'b0;
      down.valid <= 1'b0;
    end else if (enable) begin
      live       <= live_next;
      down.valid <= up.valid;
      if (hit) begin
        tail <= up.value;
      end
      down.value   <= up.value;
      down.restart <= up.restart;
      down.placed  <= up.placed | hit;
      down.slot    <= hit ? lnds_pkg::SLOT_W'(idx) : up.slot;
      down.count   <= live_next ? here_count : up.count;
    end
  end

endmodule
`default_nettype wire

// ===== src/longest_nondecreasing_subseq_length.sv =====
// Top level: a row of tail cells computing the longest non-decreasing subsequence length.
// Each request walks down a row of MAX_LEN tail cells, one cell per cycle while the row
// is not stalled, and its result is shown from the register of the last cell;
// requests follow one another through the row, and one request is accepted in every
// cycle in which the result register is free or being read. A set restart bit empties
// each cell just ahead of its own request. The row stalls as a whole while a result
// waits to be taken.
`default_nettype none
module longest_nondecreasing_subseq_length (
  input  wire logic  clk,
  input  wire logic  rst,
  lnds_req_if.sink   item,
  lnds_res_if.source result
);

  lnds_pkg::item_t stage [0:lnds_pkg::MAX_LEN];
  logic            enable;
  lnds_pkg::item_t last;

  assign last   = stage[lnds_pkg::MAX_LEN];
  assign enable = ~last.valid | result.ready;
  assign item.ready = enable;

  always_comb begin
    stage[0]         = '0;
    stage[0].valid   = item.valid;
    stage[0].value   = item.value;
    stage[0].restart = item.restart;
  end

  for (genvar k = 0; k < lnds_pkg::MAX_LEN; k++) begin : g_cell
    lnds_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .enable (enable),
      .idx    (lnds_pkg::IDX_W'(k)),
      .up     (stage[k]),
      .down   (stage[k+1])
    );
  end

  assign result.valid      = last.valid;
  assign result.slot       = last.slot;
  assign result.run_length = last.count;
  assign result.overflow   = ~last.placed;

endmodule
`default_nettype wire

// ===== src/lnds_checker.sv =====
// Port-level checks for the subsequence block, with the bind that attaches them.
`default_nettype none
module lnds_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          res_valid,
  input wire logic                          res_ready,
  input wire logic [lnds_pkg::SLOT_W-1:0]   slot,
  input wire logic [lnds_pkg::RUN_W-1:0]    run_length,
  input wire logic                          overflow
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("Result valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(slot) && $stable(run_length))
    else $error("Stalled result changed.");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid && overflow |-> slot == '0
      && run_length == lnds_pkg::RUN_W'(lnds_pkg::MAX_LEN))
    else $error("Overflow result with a live slot or a short store.");

  a_slot_live: assert property (@(posedge clk) disable iff (rst)
    res_valid && !overflow |-> {1'b0, slot} < run_length && run_length != '0)
    else $error("Written slot beyond the running length.");

endmodule

bind longest_nondecreasing_subseq_length lnds_checker u_lnds_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .slot       (result.slot),
  .run_length (result.run_length),
  .overflow   (result.overflow)
);
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the longest non-decreasing subsequence length block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [lnds_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [lnds_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int DRAIN_CYCLES = lnds_pkg::MAX_LEN + 64;
  localparam int N_DIRECTED = 22;
  localparam int IDLE_LEVELS [4] = '{0, 5, 20, 50};

  typedef enum {SPREAD_FULL, SPREAD_NARROW, SPREAD_RISING} spread_t;

  typedef struct packed {
    logic [lnds_pkg::SLOT_W-1:0] slot;
    logic [lnds_pkg::RUN_W-1:0]  run_length;
    logic                        overflow;
  } placement_t;

  typedef struct packed {
    logic signed [lnds_pkg::VAL_W-1:0] value;
    logic                              restart;
    logic                              typed;
    placement_t                        placement;
  } vector_t;

  localparam vector_t DIRECTED_VECTORS [N_DIRECTED] = '{
    '{32'sd0,           1'b0, 1'b1, '{10'd0, 11'd1, 1'b0}},
    '{VAL_MIN,          1'b0, 1'b1, '{10'd0, 11'd1, 1'b0}},
    '{VAL_MAX,          1'b0, 1'b1, '{10'd1, 11'd2, 1'b0}},
    '{VAL_MAX,          1'b0, 1'b1, '{10'd2, 11'd3, 1'b0}},
    '{32'sd5,           1'b0, 1'b0, '0},
    '{32'sd5,           1'b0, 1'b0, '0},
    '{-32'sd1,          1'b0, 1'b0, '0},
    '{VAL_MAX,          1'b1, 1'b1, '{10'd0, 11'd1, 1'b0}},
    '{VAL_MIN,          1'b1, 1'b1, '{10'd0, 11'd1, 1'b0}},
    '{VAL_MIN,          1'b0, 1'b1, '{10'd1, 11'd2, 1'b0}},
    '{VAL_MIN,          1'b0, 1'b1, '{10'd2, 11'd3, 1'b0}},
    '{-32'sd2,          1'b0, 1'b0, '0},
    '{32'sh5555_5555,   1'b0, 1'b0, '0},
    '{32'shAAAA_AAAA,   1'b0, 1'b0, '0},
    '{32'sd1,           1'b0, 1'b0, '0},
    '{32'sh7FFF_FFFE,   1'b0, 1'b0, '0},
    '{32'sd0,           1'b1, 1'b1, '{10'd0, 11'd1, 1'b0}},
    '{32'sd3,           1'b0, 1'b0, '0},
    '{32'sd2,           1'b0, 1'b0, '0},
    '{32'sd1,           1'b0, 1'b0, '0},
    '{32'sd2,           1'b0, 1'b0, '0},
    '{32'sd4,           1'b0, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;
  bit quiet = 1'b0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned requests = 0;
  int unsigned restarts = 0;
  int unsigned overflows_seen = 0;
  logic [lnds_pkg::RUN_W-1:0] longest_seen = '0;

  logic signed [lnds_pkg::VAL_W-1:0] tail_store [lnds_pkg::MAX_LEN];
  int unsigned tail_count;
  placement_t expected_placements [$];

  lnds_req_if req_ch ();
  lnds_res_if res_ch ();

  longest_nondecreasing_subseq_length u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (req_ch),
    .result (res_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic placement_t place_value(logic signed [lnds_pkg::VAL_W-1:0] v, logic rs);
    placement_t p;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    if (rs) begin
      foreach (tail_store[i]) tail_store[i] = VAL_MAX;
      tail_count = 0;
    end
    lo = 0;
    hi = tail_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tail_store[mid] > v) hi = mid;
      else lo = mid + 1;
    end
    p = '0;
    if (lo < tail_count) begin
      tail_store[lo] = v;
      p.slot = lo[lnds_pkg::SLOT_W-1:0];
    end else if (tail_count < lnds_pkg::MAX_LEN) begin
      tail_store[lo] = v;
      p.slot = lo[lnds_pkg::SLOT_W-1:0];
      tail_count++;
    end else begin
      p.overflow = 1'b1;
    end
    p.run_length = tail_count[lnds_pkg::RUN_W-1:0];
    return p;
  endfunction

  task automatic send_request(logic signed [lnds_pkg::VAL_W-1:0] v, logic rs, int idle_pct,
                              logic typed, placement_t typed_result);
    placement_t p;
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.value   <= v;
    req_ch.restart <= rs;
    do @(posedge clk); while (!req_ch.ready);
    p = place_value(v, rs);
    expected_placements.insert(expected_placements.size(), typed ? typed_result : p);
    requests++;
    if (rs) restarts++;
  endtask

  task automatic send_sequence(int len, spread_t spread, int idle_pct, bit fresh);
    logic signed [lnds_pkg::VAL_W-1:0] v;
    longint walk;
    walk = $signed($urandom);
    for (int k = 0; k < len; k++) begin
      case (spread)
        SPREAD_FULL: v = $urandom;
        SPREAD_NARROW: v = $signed($urandom_range(0, 16)) - 8;
        default: begin
          walk += $urandom_range(0, 4000);
          if ($urandom_range(0, 4) == 0) walk -= $urandom_range(0, 12000);
          if (walk > VAL_MAX) walk = VAL_MAX;
          if (walk < VAL_MIN) walk = VAL_MIN;
          v = walk[lnds_pkg::VAL_W-1:0];
        end
      endcase
      if ($urandom_range(0, 24) == 0) v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
      send_request(v, (k == 0 && fresh) || $urandom_range(0, 39) == 0, idle_pct, 1'b0, '0);
    end
  endtask

  // Fill the whole store with a rising run, then push values past its end.
  task automatic fill_store(int idle_pct);
    logic signed [lnds_pkg::VAL_W-1:0] v;
    longint walk;
    walk = VAL_MIN;
    walk += $urandom_range(0, 1000);
    for (int k = 0; k < lnds_pkg::MAX_LEN; k++) begin
      send_request(walk[lnds_pkg::VAL_W-1:0], k == 0, idle_pct, 1'b0, '0);
      walk += $urandom_range(0, 1 << 20);
    end
    for (int k = 0; k < 40; k++) begin
      if (k % 8 == 0) begin
        v = VAL_MAX;
      end else if (k % 2 == 0) begin
        v = walk[lnds_pkg::VAL_W-1:0];
        walk += $urandom_range(0, 3);
      end else begin
        v = $urandom;
      end
      send_request(v, 1'b0, idle_pct, 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_placements.size() != 0);
  endtask

  initial begin
    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.value   <= '0;
    req_ch.restart <= 1'b0;
    foreach (tail_store[i]) tail_store[i] = VAL_MAX;
    tail_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_VECTORS[i]) begin
      send_request(DIRECTED_VECTORS[i].value, DIRECTED_VECTORS[i].restart, 25,
                   DIRECTED_VECTORS[i].typed, DIRECTED_VECTORS[i].placement);
    end

    repeat (15) begin
      send_sequence($urandom_range(1, 14), spread_t'($urandom_range(0, 2)),
                    IDLE_LEVELS[$urandom_range(0, 3)], $urandom_range(0, 4) != 0);
    end

    wait_drained();
    fill_store(5);

    quiet = 1'b1;
    repeat (5) begin
      send_sequence($urandom_range(4, 12), spread_t'($urandom_range(0, 2)), 0, 1'b1);
    end

    req_ch.valid <= 1'b0;
    while (expected_placements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests, %0d of them with restart, in %0d cycles.",
             requests, restarts, cycles);
    $display("Longest run reported: %0d; dropped on a full store: %0d.",
             longest_seen, overflows_seen);
    if (errors == 0 && expected_placements.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int stretch;
    res_ch.ready <= 1'b0;
    repeat (8) @(posedge clk);
    forever begin
      stretch = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
      res_ch.ready <= 1'b1;
      repeat (stretch) @(posedge clk);
      if (!quiet && $urandom_range(0, 1) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    placement_t got;
    placement_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.slot, res_ch.run_length, res_ch.overflow};
      if (got.overflow) overflows_seen++;
      if (got.run_length > longest_seen) longest_seen = got.run_length;
      if (expected_placements.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected result: slot %0d run_length %0d overflow %0b",
                   got.slot, got.run_length, got.overflow);
        end
      end else begin
        want = expected_placements.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("Mismatch: slot %0d/%0d run_length %0d/%0d overflow %0b/%0b (exp/got)",
                     want.slot, got.slot, want.run_length, got.run_length,
                     want.overflow, got.overflow);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, expected_placements.size());
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

// ===== files.f =====
src/lnds_pkg.sv
src/lnds_if.sv
src/lnds_cell.sv
src/longest_nondecreasing_subseq_length.sv
src/lnds_checker.sv
dv/testbench.sv
